>>> design/mtt_pkg.sv
package mtt_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam int ID_W   = 31;
   localparam int CB_W   = 16;
   localparam int IVL_W  = 31;
   localparam int TIME_W = 32;

   // request codes on req_type
   localparam logic [2:0] REQ_SET      = 3'd0;
   localparam logic [2:0] REQ_KILL     = 3'd1;
   localparam logic [2:0] REQ_KILL_ALL = 3'd2;
   localparam logic [2:0] REQ_QUERY    = 3'd3;
   localparam logic [2:0] REQ_TICK     = 3'd4;

   // result kinds on rsp_result_kind
   localparam logic [2:0] KIND_SET_ACK      = 3'd0;
   localparam logic [2:0] KIND_KILL_ACK     = 3'd1;
   localparam logic [2:0] KIND_KILL_ALL_ACK = 3'd2;
   localparam logic [2:0] KIND_QUERY        = 3'd3;
   localparam logic [2:0] KIND_FIRE         = 3'd4;

   typedef enum logic [2:0] {
      OP_SET,
      OP_KILL,
      OP_KILL_ALL,
      OP_QUERY,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   timer_id;
      logic [CB_W-1:0]   callback;
      logic [IVL_W-1:0]  interval;
      logic              repeat_en;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

>>> design/mtt_front.sv
module mtt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_type,
   input  logic [mtt_pkg::ID_W-1:0]   req_timer_id,
   input  logic [mtt_pkg::CB_W-1:0]   req_callback_index,
   input  logic [mtt_pkg::IVL_W-1:0]  req_interval_ms,
   input  logic                       req_repeat_req,
   output mtt_pkg::queue_out_type     queue_out,
   input  logic                       queue_pop
);
   import mtt_pkg::*;

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_new;
   logic                known;
   logic                push;
   logic                pop;

   // classify the request; unknown codes are taken and dropped here
   always_comb begin
      known = 1'b1;
      cmd_new.op = OP_TICK;
      case (req_type)
         REQ_SET:      cmd_new.op = OP_SET;
         REQ_KILL:     cmd_new.op = OP_KILL;
         REQ_KILL_ALL: cmd_new.op = OP_KILL_ALL;
         REQ_QUERY:    cmd_new.op = OP_QUERY;
         REQ_TICK:     cmd_new.op = OP_TICK;
         default:      known = 1'b0;
      endcase
      cmd_new.timer_id  = req_timer_id;
      cmd_new.callback  = req_callback_index;
      cmd_new.interval  = req_interval_ms;
      cmd_new.repeat_en = req_repeat_req;
   end

   assign busy = (count_ff == QCNT_W'(QDEPTH));
   assign push = start && !busy && known;
   assign pop  = queue_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.cmd   = q_ff[rd_ptr_ff];

endmodule

>>> design/mtt_back.sv
module mtt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mtt_pkg::queue_out_type      queue_out,
   output logic                        queue_pop,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_result_kind,
   output logic [mtt_pkg::ID_W-1:0]    rsp_result_id,
   output logic [mtt_pkg::CB_W-1:0]    rsp_fired_callback,
   output logic                        rsp_flag,
   output logic                        rsp_last
);
   import mtt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DROP = 4'b0100,
      S_FIRE = 4'b1000
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic                   hit_ff, hit_in;
   logic                   free_found_ff, free_found_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;
   logic [ID_W-1:0]        id_counter_ff, id_counter_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [NUM_TIMERS-1:0]  valid_ff, valid_in;
   logic [NUM_TIMERS-1:0]  destroyed_ff, destroyed_in;
   logic [NUM_TIMERS-1:0]  due_ff, due_in;
   logic                   best_found_ff, best_found_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic [ID_W-1:0]        best_id_ff, best_id_in;
   logic [CB_W-1:0]        best_cb_ff, best_cb_in;
   logic                   best_rep_ff, best_rep_in;
   logic [FCNT_W-1:0]      fire_cnt_ff, fire_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [CB_W-1:0]        rsp_cb_ff, rsp_cb_in;
   logic                   rsp_flag_ff, rsp_flag_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   slot_repeat_ff   [NUM_TIMERS];
   logic [ID_W-1:0]        slot_id_ff       [NUM_TIMERS];
   logic [CB_W-1:0]        slot_callback_ff [NUM_TIMERS];
   logic [IVL_W-1:0]       slot_interval_ff [NUM_TIMERS];
   logic [TIME_W-1:0]      slot_start_ff    [NUM_TIMERS];

   logic                   slot_wr;
   logic [SLOT_W-1:0]      slot_wr_idx;
   logic                   start_wr;
   logic [SLOT_W-1:0]      start_wr_idx;

   logic                   rd_valid;
   logic                   rd_destroyed;
   logic [ID_W-1:0]        rd_id;
   logic [CB_W-1:0]        rd_cb;
   logic                   rd_rep;
   logic [TIME_W-1:0]      elapsed;
   logic                   last_slot;
   logic [ID_W-1:0]        key;
   logic                   match;
   logic                   hit_now;
   logic                   free_found_now;
   logic [SLOT_W-1:0]      free_idx_now;
   logic                   store;
   logic                   cand;
   logic                   best_found_now;
   logic [SLOT_W-1:0]      best_idx_now;
   logic [ID_W-1:0]        best_id_now;
   logic [CB_W-1:0]        best_cb_now;
   logic                   best_rep_now;
   logic [NUM_TIMERS-1:0]  best_mask;
   logic                   final_fire;

   // one slot is looked at per cycle, through the scan index
   assign rd_valid     = valid_ff[idx_ff];
   assign rd_destroyed = destroyed_ff[idx_ff];
   assign rd_id        = slot_id_ff[idx_ff];
   assign rd_cb        = slot_callback_ff[idx_ff];
   assign rd_rep       = slot_repeat_ff[idx_ff];
   assign elapsed      = now_ff - slot_start_ff[idx_ff];
   assign last_slot    = (idx_ff == LAST_SLOT);

   assign key            = (cmd_ff.op == OP_SET) ? id_counter_ff : cmd_ff.timer_id;
   assign match          = rd_valid && (rd_id == key);
   assign hit_now        = hit_ff || match;
   assign free_found_now = free_found_ff || !rd_valid;
   assign free_idx_now   = free_found_ff ? free_idx_ff : idx_ff;
   assign store          = !hit_now && free_found_now;

   // running minimum over due slots
   assign cand           = due_ff[idx_ff] && (!best_found_ff || (rd_id < best_id_ff));
   assign best_found_now = best_found_ff || cand;
   assign best_idx_now   = cand ? idx_ff : best_idx_ff;
   assign best_id_now    = cand ? rd_id  : best_id_ff;
   assign best_cb_now    = cand ? rd_cb  : best_cb_ff;
   assign best_rep_now   = cand ? rd_rep : best_rep_ff;

   always_comb begin
      best_mask = '0;
      best_mask[best_idx_now] = 1'b1;
   end

   assign final_fire = ((due_ff & ~best_mask) == '0) ||
                       (fire_cnt_ff == FCNT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      id_counter_in = id_counter_ff;
      now_in        = now_ff;
      valid_in      = valid_ff;
      destroyed_in  = destroyed_ff;
      due_in        = due_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_cb_in    = best_cb_ff;
      best_rep_in   = best_rep_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cb_in     = rsp_cb_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_last_in   = rsp_last_ff;
      queue_pop     = 1'b0;
      slot_wr       = 1'b0;
      slot_wr_idx   = free_idx_now;
      start_wr      = 1'b0;
      start_wr_idx  = best_idx_now;

      case (state_ff)
         S_IDLE: begin
            if (queue_out.valid) begin
               queue_pop     = 1'b1;
               cmd_in        = queue_out.cmd;
               idx_in        = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               best_found_in = 1'b0;
               fire_cnt_in   = '0;
               case (queue_out.cmd.op)
                  OP_SET: begin
                     id_counter_in = id_counter_ff + ID_W'(1);
                     state_in      = S_SCAN;
                  end
                  OP_KILL, OP_QUERY: begin
                     state_in = S_SCAN;
                  end
                  OP_KILL_ALL: begin
                     valid_in     = '0;
                     destroyed_in = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_KILL_ALL_ACK;
                     rsp_id_in    = '0;
                     rsp_cb_in    = '0;
                     rsp_flag_in  = 1'b0;
                     rsp_last_in  = 1'b1;
                  end
                  OP_TICK: begin
                     now_in   = now_ff + TIME_W'(1);
                     state_in = S_DROP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            hit_in        = hit_now;
            free_found_in = free_found_now;
            free_idx_in   = free_idx_now;
            idx_in        = idx_ff + SLOT_W'(1);
            if (cmd_ff.op == OP_KILL && match) begin
               destroyed_in[idx_ff] = 1'b1;
            end
            if (last_slot) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_cb_in    = '0;
               rsp_last_in  = 1'b1;
               rsp_id_in    = cmd_ff.timer_id;
               case (cmd_ff.op)
                  OP_SET: begin
                     rsp_kind_in = KIND_SET_ACK;
                     rsp_id_in   = id_counter_ff;
                     rsp_flag_in = !store;
                     if (store) begin
                        slot_wr                    = 1'b1;
                        valid_in[free_idx_now]     = 1'b1;
                        destroyed_in[free_idx_now] = 1'b0;
                     end
                  end
                  OP_KILL: begin
                     rsp_kind_in = KIND_KILL_ACK;
                     rsp_flag_in = !hit_now;
                  end
                  default: begin
                     rsp_kind_in = KIND_QUERY;
                     rsp_flag_in = hit_now;
                  end
               endcase
            end
         end

         S_DROP: begin
            // killed timers leave on the tick without firing
            if (rd_valid && rd_destroyed) begin
               valid_in[idx_ff]     = 1'b0;
               destroyed_in[idx_ff] = 1'b0;
               due_in[idx_ff]       = 1'b0;
            end else begin
               due_in[idx_ff] = rd_valid &&
                                (elapsed >= {1'b0, slot_interval_ff[idx_ff]});
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (last_slot) begin
               idx_in        = '0;
               best_found_in = 1'b0;
               state_in      = S_FIRE;
            end
         end

         S_FIRE: begin
            best_found_in = best_found_now;
            best_idx_in   = best_idx_now;
            best_id_in    = best_id_now;
            best_cb_in    = best_cb_now;
            best_rep_in   = best_rep_now;
            idx_in        = idx_ff + SLOT_W'(1);
            if (last_slot) begin
               idx_in        = '0;
               best_found_in = 1'b0;
               state_in      = S_IDLE;
               if (best_found_now) begin
                  rsp_valid_in         = 1'b1;
                  rsp_kind_in          = KIND_FIRE;
                  rsp_id_in            = best_id_now;
                  rsp_cb_in            = best_cb_now;
                  rsp_flag_in          = 1'b0;
                  rsp_last_in          = final_fire;
                  due_in[best_idx_now] = 1'b0;
                  fire_cnt_in          = fire_cnt_ff + FCNT_W'(1);
                  if (best_rep_now) begin
                     start_wr = 1'b1;
                  end else begin
                     valid_in[best_idx_now] = 1'b0;
                  end
                  if (!final_fire) begin
                     state_in = S_FIRE;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         destroyed_ff  <= '0;
         id_counter_ff <= '0;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         destroyed_ff  <= destroyed_in;
         id_counter_ff <= id_counter_in;
         now_ff        <= now_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      due_ff        <= due_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_id_ff    <= best_id_in;
      best_cb_ff    <= best_cb_in;
      best_rep_ff   <= best_rep_in;
      fire_cnt_ff   <= fire_cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cb_ff     <= rsp_cb_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_repeat_ff[slot_wr_idx]   <= cmd_ff.repeat_en;
         slot_id_ff[slot_wr_idx]       <= id_counter_ff;
         slot_callback_ff[slot_wr_idx] <= cmd_ff.callback;
         slot_interval_ff[slot_wr_idx] <= cmd_ff.interval;
      end
      if (slot_wr) begin
         slot_start_ff[slot_wr_idx] <= now_ff;
      end else if (start_wr) begin
         slot_start_ff[start_wr_idx] <= now_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_fired_callback = rsp_cb_ff;
   assign rsp_flag           = rsp_flag_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

>>> design/multi_timer_table.sv
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+--------------------------
// request   | req_type, req_timer_id, req_callback_index,    | taken when start & !busy
//           | req_interval_ms, req_repeat_req                |
// result    | rsp_result_kind, rsp_result_id,                | one cycle, rsp_valid high
//           | rsp_fired_callback, rsp_flag, rsp_last         |
//
// requests go into a two-entry queue; busy is high only while it is full.
// set, kill and query scan every slot in the engine (one slot per cycle); kill-all acts at once.
// a tick advances time, then one pass over the slots drops killed timers and marks due
// ones, then a minimum-id search over all slots per fired timer, one even when none is due.
// reset is synchronous and empties the table, the queue and both counters.
// results cannot be held off; a result shows for exactly one cycle.
module multi_timer_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_type,
   input  logic [mtt_pkg::ID_W-1:0]   req_timer_id,
   input  logic [mtt_pkg::CB_W-1:0]   req_callback_index,
   input  logic [mtt_pkg::IVL_W-1:0]  req_interval_ms,
   input  logic                       req_repeat_req,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_result_kind,
   output logic [mtt_pkg::ID_W-1:0]   rsp_result_id,
   output logic [mtt_pkg::CB_W-1:0]   rsp_fired_callback,
   output logic                       rsp_flag,
   output logic                       rsp_last
);
   import mtt_pkg::*;

   queue_out_type queue_out;
   logic          queue_pop;

   mtt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_timer_id       (req_timer_id),
      .req_callback_index (req_callback_index),
      .req_interval_ms    (req_interval_ms),
      .req_repeat_req     (req_repeat_req),
      .queue_out          (queue_out),
      .queue_pop          (queue_pop)
   );

   mtt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_out          (queue_out),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_result_id      (rsp_result_id),
      .rsp_fired_callback (rsp_fired_callback),
      .rsp_flag           (rsp_flag),
      .rsp_last           (rsp_last)
   );

endmodule
